// ===== rtl/dfs_cycle_check_topo_order_unit_macros.svh =====
// Assertion macros used by the checker file of the block.
`ifndef DFS_CYCLE_CHECK_TOPO_ORDER_UNIT_MACROS_SVH
`define DFS_CYCLE_CHECK_TOPO_ORDER_UNIT_MACROS_SVH

// Antecedent holds in one cycle, consequent must hold in the next one.
`define DCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcc assertion failed");

// Antecedent and consequent in the same cycle.
`define DCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcc assertion failed");

// Next-cycle check that stays active through reset.
`define DCC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dcc assertion failed");

`endif

// ===== rtl/dcc_pkg.sv =====
package dcc_pkg;

  // Fixed field widths of the stream items and the configuration register.
  localparam int CMD_W       = 2;
  localparam int NODE_W      = 4;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 1;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2
  } cmd_t;

endpackage

// ===== rtl/dfs_cycle_check_topo_order_unit.sv =====
// Directed-graph cycle check with topological sort. Edges are loaded one transfer at a
// time into an adjacency memory (one row per source node); a clear command drops all
// edges by clearing the row-valid flags, and an add command steps through accept, row
// read and row write back. A run command performs a depth-first search over nodes 0 to
// the effective node count minus one, roots and successors in ascending index order,
// scanning one adjacency bit per cycle. Each node passes through a row fetch, the
// successor scan, a finish step, a stack pop and a second fetch of the parent's row;
// the single-bit scan of the registered adjacency row sets the run time before the
// first result. If an edge reaches a node still on the search path, the search stops,
// the parent chain is walked back through the parent memory (a check state and a wait
// state per node), and the cycle is delivered as node, target, then the path from the
// child of target down to node, all with tuser set. Otherwise every node is delivered
// in reverse postorder with tuser clear. The node and target of a cycle leave from
// successive emit states, each waiting for a free output slot; every other result
// passes through a stack read, then the output register, and tlast marks the final
// result of a run. The input is taken only while the block is idle, but a new transfer
// is accepted while the last result of a run still waits in the output register.
module dfs_cycle_check_topo_order_unit #(
  parameter int MAX_NODES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration: node_count, written whenever cfg_wr_en is high.
  input  logic                              cfg_wr_en,
  input  logic [dcc_pkg::CFG_W-1:0]         cfg_wr_data,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dcc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [3:0] src_node, [7:4] dst_node
  input  logic [dcc_pkg::IN_TUSER_W-1:0]    in_tuser,   // [1:0] command
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dcc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [3:0] node, [7:4] zero
  output logic [dcc_pkg::OUT_TUSER_W-1:0]   out_tuser,  // [0] has_cycle
  output logic                              out_tlast   // last
);
  import dcc_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int WK_W  = IDX_W + CNT_W;
  localparam logic [MAX_NODES-1:0] ROW_ONE = {{(MAX_NODES-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_ROOT,
    ST_FETCH,
    ST_SCAN,
    ST_POP_WAIT,
    ST_CHAIN_CHK,
    ST_CHAIN_WAIT,
    ST_EMIT_N,
    ST_EMIT_T,
    ST_POP_RD,
    ST_POP_OUT
  } state_t;

  // Control and search registers.
  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      node_count_r;
  logic [MAX_NODES-1:0]  adj_vld_r, adj_vld_nxt;
  logic [MAX_NODES-1:0]  visited_r, visited_nxt;
  logic [MAX_NODES-1:0]  on_path_r, on_path_nxt;
  logic [IDX_W-1:0]      src_r, src_nxt;
  logic [IDX_W-1:0]      dst_r, dst_nxt;
  logic [CNT_W-1:0]      root_r, root_nxt;
  logic [IDX_W-1:0]      top_node_r, top_node_nxt;
  logic [CNT_W-1:0]      top_next_r, top_next_nxt;
  logic [CNT_W-1:0]      depth_r, depth_nxt;
  logic [CNT_W-1:0]      olen_r, olen_nxt;
  logic [IDX_W-1:0]      cyc_n_r, cyc_n_nxt;
  logic [IDX_W-1:0]      cyc_t_r, cyc_t_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic                  cyc_flag_r, cyc_flag_nxt;

  // Output register.
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [NODE_W-1:0]     out_node_r, out_node_nxt;
  logic                  out_cyc_r, out_cyc_nxt;
  logic                  out_last_r, out_last_nxt;

  // Memories: adjacency rows, parent links, search stack, finished-node stack.
  logic [MAX_NODES-1:0]  adj_mem [MAX_NODES];
  logic                  adj_we, adj_re;
  logic [IDX_W-1:0]      adj_waddr, adj_raddr;
  logic [MAX_NODES-1:0]  adj_wdata, adj_rdata_r;
  logic                  adj_rvld_r;

  logic [IDX_W-1:0]      par_mem [MAX_NODES];
  logic                  par_we, par_re;
  logic [IDX_W-1:0]      par_waddr, par_raddr, par_wdata, par_rdata_r;

  logic [WK_W-1:0]       wk_mem [MAX_NODES];
  logic                  wk_we, wk_re;
  logic [IDX_W-1:0]      wk_waddr, wk_raddr;
  logic [WK_W-1:0]       wk_wdata, wk_rdata_r;

  logic [IDX_W-1:0]      ord_mem [MAX_NODES];
  logic                  ord_we, ord_re;
  logic [IDX_W-1:0]      ord_waddr, ord_raddr, ord_wdata, ord_rdata_r;

  // Derived values.
  logic [CMP_W-1:0]      nc_ext;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      t_idx, root_idx;
  logic [CNT_W-1:0]      depth_m1, depth_m2, olen_m1, next_p1;
  logic                  row_bit;
  logic                  slot_free;
  logic                  in_xfer;
  logic                  edge_ok;
  logic [NODE_W-1:0]     in_src, in_dst;
  cmd_t                  in_cmd;

  // Effective node count: zero acts as one, values above MAX_NODES saturate.
  assign nc_ext = CMP_W'(node_count_r);
  always_comb begin
    if (nc_ext == '0) begin
      cnt = CNT_W'(1);
    end else if (nc_ext > CMP_W'(MAX_NODES)) begin
      cnt = CNT_W'(MAX_NODES);
    end else begin
      cnt = CNT_W'(nc_ext);
    end
  end

  assign in_src   = in_tdata[NODE_W-1:0];
  assign in_dst   = in_tdata[2*NODE_W-1:NODE_W];
  assign in_cmd   = cmd_t'(in_tuser);
  assign edge_ok  = (32'(in_src) < 32'(MAX_NODES)) && (32'(in_dst) < 32'(MAX_NODES));

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign t_idx     = top_next_r[IDX_W-1:0];
  assign root_idx  = root_r[IDX_W-1:0];
  assign depth_m1  = depth_r - CNT_W'(1);
  assign depth_m2  = depth_r - CNT_W'(2);
  assign olen_m1   = olen_r - CNT_W'(1);
  assign next_p1   = top_next_r + CNT_W'(1);
  // A row that was never written since the last clear reads as empty.
  assign row_bit   = adj_rvld_r && adj_rdata_r[t_idx];
  assign slot_free = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_node_r);
  assign out_tuser  = out_cyc_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    adj_vld_nxt    = adj_vld_r;
    visited_nxt    = visited_r;
    on_path_nxt    = on_path_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    root_nxt       = root_r;
    top_node_nxt   = top_node_r;
    top_next_nxt   = top_next_r;
    depth_nxt      = depth_r;
    olen_nxt       = olen_r;
    cyc_n_nxt      = cyc_n_r;
    cyc_t_nxt      = cyc_t_r;
    cur_nxt        = cur_r;
    cyc_flag_nxt   = cyc_flag_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_node_nxt   = out_node_r;
    out_cyc_nxt    = out_cyc_r;
    out_last_nxt   = out_last_r;

    adj_we = 1'b0;  adj_waddr = src_r;  adj_wdata = '0;
    adj_re = 1'b0;  adj_raddr = top_node_r;
    par_we = 1'b0;  par_waddr = t_idx;  par_wdata = top_node_r;
    par_re = 1'b0;  par_raddr = cur_r;
    wk_we  = 1'b0;  wk_waddr  = depth_m1[IDX_W-1:0];  wk_wdata = {top_node_r, next_p1};
    wk_re  = 1'b0;  wk_raddr  = depth_m2[IDX_W-1:0];
    ord_we = 1'b0;  ord_waddr = olen_r[IDX_W-1:0];    ord_wdata = top_node_r;
    ord_re = 1'b0;  ord_raddr = olen_m1[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_CLEAR: begin
              adj_vld_nxt = '0;
            end
            CMD_ADD: begin
              src_nxt = IDX_W'(in_src);
              dst_nxt = IDX_W'(in_dst);
              if (edge_ok) begin
                state_nxt = ST_ADD_RD;
              end
            end
            CMD_RUN: begin
              visited_nxt  = '0;
              on_path_nxt  = '0;
              root_nxt     = '0;
              olen_nxt     = '0;
              cyc_flag_nxt = 1'b0;
              state_nxt    = ST_ROOT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_ADD_RD: begin
        adj_re    = 1'b1;
        adj_raddr = src_r;
        state_nxt = ST_ADD_WR;
      end

      ST_ADD_WR: begin
        adj_we      = 1'b1;
        adj_waddr   = src_r;
        adj_wdata   = (adj_rvld_r ? adj_rdata_r : '0) | (ROW_ONE << dst_r);
        adj_vld_nxt = adj_vld_r | (ROW_ONE << src_r);
        state_nxt   = ST_IDLE;
      end

      ST_ROOT: begin
        if (root_r >= cnt) begin
          // Search finished without a back edge: deliver the reverse postorder.
          state_nxt = ST_POP_RD;
        end else if (visited_r[root_idx]) begin
          root_nxt = root_r + CNT_W'(1);
        end else begin
          visited_nxt  = visited_r | (ROW_ONE << root_idx);
          on_path_nxt  = on_path_r | (ROW_ONE << root_idx);
          top_node_nxt = root_idx;
          top_next_nxt = '0;
          depth_nxt    = CNT_W'(1);
          state_nxt    = ST_FETCH;
        end
      end

      ST_FETCH: begin
        adj_re    = 1'b1;
        adj_raddr = top_node_r;
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        if (top_next_r >= cnt) begin
          // All successors done: the node is finished.
          ord_we      = 1'b1;
          olen_nxt    = olen_r + CNT_W'(1);
          on_path_nxt = on_path_r & ~(ROW_ONE << top_node_r);
          depth_nxt   = depth_m1;
          if (depth_r == CNT_W'(1)) begin
            root_nxt  = root_r + CNT_W'(1);
            state_nxt = ST_ROOT;
          end else begin
            wk_re     = 1'b1;
            state_nxt = ST_POP_WAIT;
          end
        end else begin
          top_next_nxt = next_p1;
          if (row_bit) begin
            if (!visited_r[t_idx]) begin
              // Descend: save the current frame, the successor becomes the top.
              par_we       = 1'b1;
              wk_we        = 1'b1;
              visited_nxt  = visited_r | (ROW_ONE << t_idx);
              on_path_nxt  = on_path_r | (ROW_ONE << t_idx);
              top_node_nxt = t_idx;
              top_next_nxt = '0;
              depth_nxt    = depth_r + CNT_W'(1);
              state_nxt    = ST_FETCH;
            end else if (on_path_r[t_idx]) begin
              cyc_n_nxt = top_node_r;
              cyc_t_nxt = t_idx;
              cur_nxt   = top_node_r;
              olen_nxt  = '0;
              state_nxt = ST_CHAIN_CHK;
            end
          end
        end
      end

      ST_POP_WAIT: begin
        top_node_nxt = wk_rdata_r[WK_W-1:CNT_W];
        top_next_nxt = wk_rdata_r[CNT_W-1:0];
        state_nxt    = ST_FETCH;
      end

      ST_CHAIN_CHK: begin
        if (cur_r == cyc_t_r) begin
          cyc_flag_nxt = 1'b1;
          state_nxt    = ST_EMIT_N;
        end else begin
          ord_we    = 1'b1;
          ord_wdata = cur_r;
          olen_nxt  = olen_r + CNT_W'(1);
          par_re    = 1'b1;
          par_raddr = cur_r;
          state_nxt = ST_CHAIN_WAIT;
        end
      end

      ST_CHAIN_WAIT: begin
        cur_nxt   = par_rdata_r;
        state_nxt = ST_CHAIN_CHK;
      end

      ST_EMIT_N: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_node_nxt   = NODE_W'(cyc_n_r);
          out_cyc_nxt    = 1'b1;
          out_last_nxt   = 1'b0;
          state_nxt      = ST_EMIT_T;
        end
      end

      ST_EMIT_T: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_node_nxt   = NODE_W'(cyc_t_r);
          out_cyc_nxt    = 1'b1;
          out_last_nxt   = (olen_r == '0);
          state_nxt      = (olen_r == '0) ? ST_IDLE : ST_POP_RD;
        end
      end

      ST_POP_RD: begin
        ord_re    = 1'b1;
        state_nxt = ST_POP_OUT;
      end

      ST_POP_OUT: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_node_nxt   = NODE_W'(ord_rdata_r);
          out_cyc_nxt    = cyc_flag_r;
          out_last_nxt   = (olen_r == CNT_W'(1));
          olen_nxt       = olen_m1;
          state_nxt      = (olen_r == CNT_W'(1)) ? ST_IDLE : ST_POP_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The FSM never reads an entry in the cycle it writes it, so the memories need no
  // forwarding: every stack and parent read follows its write by at least one state.
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata_r <= adj_mem[adj_raddr];
      adj_rvld_r  <= adj_vld_r[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (par_re) begin
      par_rdata_r <= par_mem[par_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk_mem[wk_waddr] <= wk_wdata;
    end
    if (wk_re) begin
      wk_rdata_r <= wk_mem[wk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ord_re) begin
      ord_rdata_r <= ord_mem[ord_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= NODE_COUNT_RESET;
      adj_vld_r    <= '0;
      visited_r    <= '0;
      on_path_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      adj_vld_r    <= adj_vld_nxt;
      visited_r    <= visited_nxt;
      on_path_r    <= on_path_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    root_r     <= root_nxt;
    top_node_r <= top_node_nxt;
    top_next_r <= top_next_nxt;
    depth_r    <= depth_nxt;
    olen_r     <= olen_nxt;
    cyc_n_r    <= cyc_n_nxt;
    cyc_t_r    <= cyc_t_nxt;
    cur_r      <= cur_nxt;
    cyc_flag_r <= cyc_flag_nxt;
    out_node_r <= out_node_nxt;
    out_cyc_r  <= out_cyc_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== rtl/dcc_checker.sv =====
`include "dfs_cycle_check_topo_order_unit_macros.svh"

module dcc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dcc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [dcc_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  // A stalled result keeps its contents.
  `DCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // While a run still has results to deliver, no new transfer is taken.
  `DCC_ASSERT_SAME(a_busy_while_run, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

  // Reset leaves no result pending.
  `DCC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

  // The input side is watched only through its handshake.
  logic in_seen;
  assign in_seen = in_tvalid && in_tready;

  `DCC_ASSERT_SAME(a_no_take_with_partial, clk, rst_n, in_seen, !(out_tvalid && !out_tlast))

endmodule

bind dfs_cycle_check_topo_order_unit dcc_checker u_dcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
